// ===== hw/rtl/sliding_window_median_top_assert.svh =====
// Assertion macros used by the checker file
`ifndef SLIDING_WINDOW_MEDIAN_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_ASSERT_SVH

// Consequent checked in the cycle after the antecedent
`define SWM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("swm assertion failed");

// Consequent checked in the same cycle as the antecedent
`define SWM_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("swm assertion failed");

`endif

// ===== hw/rtl/swm_pkg.sv =====
// Shared constants, types and state encodings of the running median filter
package swm_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int MAX_WINDOW_DEF   = 127;
   localparam int ADDR_W           = 7;
   localparam int CNT_W            = 7;
   localparam int CFG_W            = 7;
   localparam logic [CFG_W-1:0] CFG_RESET = 7'd3;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_RUN,
      CTL_WAIT
   } ctl_state_type;

   typedef enum logic [2:0] {
      SEL_IDLE,
      SEL_LOAD,
      SEL_SWEEP,
      SEL_CHECK,
      SEL_DONE
   } sel_state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] top;
      logic [CNT_W-1:0]  cnt;
      logic              last;
   } job_type;

   typedef struct packed {
      logic valid;
      logic last;
   } sel_status_type;

endpackage

// ===== hw/rtl/swm_if.sv =====
// Valid/ready channel interfaces for samples and medians
interface swm_req_if #(parameter int SAMPLE_WIDTH = 16);
   logic                    valid;
   logic                    ready;
   logic [SAMPLE_WIDTH-1:0] sample;
   logic                    end_of_signal;

   modport source (output valid, output sample, output end_of_signal, input ready);
   modport sink   (input valid, input sample, input end_of_signal, output ready);
endinterface

interface swm_rsp_if #(parameter int SAMPLE_WIDTH = 16);
   logic                  valid;
   logic                  ready;
   logic [SAMPLE_WIDTH:0] median_value;
   logic                  final_result;

   modport source (output valid, output median_value, output final_result, input ready);
   modport sink   (input valid, input median_value, input final_result, output ready);
endinterface

// ===== hw/rtl/swm_store.sv =====
// Circular sample store: one write port, two registered read ports
module swm_store
   import swm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [ADDR_W-1:0]       wr_addr,
   input  logic [SAMPLE_WIDTH-1:0] wr_data,
   input  logic [ADDR_W-1:0]       rd_addr_a,
   input  logic [ADDR_W-1:0]       rd_addr_b,
   output logic [SAMPLE_WIDTH-1:0] rd_data_a,
   output logic [SAMPLE_WIDTH-1:0] rd_data_b
);

   logic [SAMPLE_WIDTH-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== hw/rtl/swm_select.sv =====
// Rank selection over the newest cnt samples: per candidate, a sweep counts smaller/equal
module swm_select
   import swm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  job_type                 job,
   output sel_status_type          status,
   output logic [SAMPLE_WIDTH:0]   res_value,
   input  logic                    res_ack,
   output logic [ADDR_W-1:0]       rd_addr_a,
   output logic [ADDR_W-1:0]       rd_addr_b,
   input  logic [SAMPLE_WIDTH-1:0] rd_data_a,
   input  logic [SAMPLE_WIDTH-1:0] rd_data_b
);

   sel_state_type state_ff, state_in;
   job_type job_ff;
   logic [CNT_W-1:0] i_ff, j_ff, lt_ff, eq_ff;
   logic [SAMPLE_WIDTH-1:0] lo_ff, hi_ff;
   logic lo_ok_ff, hi_ok_ff;

   logic [CNT_W-1:0] rank_lo, rank_hi;
   logic [CNT_W:0]   ge_sum;
   logic lo_hit, hi_hit, both_found, is_less, is_equal;

   // candidate i on port A, swept element j on port B
   assign rd_addr_a = job_ff.top - ADDR_W'(i_ff);
   assign rd_addr_b = job_ff.top - ADDR_W'(j_ff);

   assign is_less  = $signed(rd_data_b) < $signed(rd_data_a);
   assign is_equal = rd_data_b == rd_data_a;

   assign rank_lo = (job_ff.cnt - CNT_W'(1)) >> 1;
   assign rank_hi = job_ff.cnt >> 1;
   assign ge_sum  = {1'b0, lt_ff} + {1'b0, eq_ff};
   assign lo_hit  = ({1'b0, lt_ff} <= {1'b0, rank_lo}) && ({1'b0, rank_lo} < ge_sum);
   assign hi_hit  = ({1'b0, lt_ff} <= {1'b0, rank_hi}) && ({1'b0, rank_hi} < ge_sum);
   assign both_found = (lo_ok_ff || lo_hit) && (hi_ok_ff || hi_hit);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEL_IDLE:  if (start) state_in = SEL_LOAD;
         SEL_LOAD:  state_in = SEL_SWEEP;
         SEL_SWEEP: if (j_ff == job_ff.cnt) state_in = SEL_CHECK;
         SEL_CHECK: state_in = both_found ? SEL_DONE : SEL_LOAD;
         SEL_DONE:  if (res_ack) state_in = SEL_IDLE;
         default:   state_in = SEL_IDLE;
      endcase
   end

   always_comb begin
      status.valid = (state_ff == SEL_DONE);
      status.last  = job_ff.last;
      res_value    = {lo_ff[SAMPLE_WIDTH-1], lo_ff} + {hi_ff[SAMPLE_WIDTH-1], hi_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         SEL_IDLE: begin
            if (start) begin
               job_ff   <= job;
               i_ff     <= '0;
               lo_ok_ff <= 1'b0;
               hi_ok_ff <= 1'b0;
            end
         end
         SEL_LOAD: begin
            j_ff  <= '0;
            lt_ff <= '0;
            eq_ff <= '0;
         end
         SEL_SWEEP: begin
            // data for element j-1 arrives while j is issued
            if (j_ff != '0) begin
               if (is_less)  lt_ff <= lt_ff + CNT_W'(1);
               if (is_equal) eq_ff <= eq_ff + CNT_W'(1);
            end
            j_ff <= j_ff + CNT_W'(1);
         end
         SEL_CHECK: begin
            if (lo_hit) begin
               lo_ff    <= rd_data_a;
               lo_ok_ff <= 1'b1;
            end
            if (hi_hit) begin
               hi_ff    <= rd_data_a;
               hi_ok_ff <= 1'b1;
            end
            i_ff <= i_ff + CNT_W'(1);
         end
         SEL_DONE: begin
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== hw/rtl/sliding_window_median_top.sv =====
// Running median filter over a signed sample stream.
// req_chan (valid/ready) carries sample and end_of_signal; an item is taken when
// valid and ready are both high. rsp_chan carries median_value (one fraction bit:
// sum of the two middle values, or twice the middle) and final_result, set on the
// last result of a signal. csr_wr_en/csr_wr_data write window_size (reset 3);
// half = window_size / 2.
// Once half samples precede it, each sample yields the median centered half
// samples back; the end_of_signal sample flushes up to half+1 results.
// Samples live in a 128-entry memory; each result is found by rank selection:
// every candidate costs one sweep of the window through a second read port; a
// sample that yields no result leaves req_chan.ready high for the next sample.
// req_chan.ready is low while results are computed.
// Reset clears pointers and sample count and sets window_size to 3; the memory
// holds no reset value and needs no clearing pass.
// A stalled receiver holds the result in the output register and the engine
// waits with the next one; nothing is dropped.
module sliding_window_median_top
   import swm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int MAX_WINDOW   = MAX_WINDOW_DEF
) (
   input  logic             clock,
   input  logic             reset,
   swm_req_if.sink          req_chan,
   swm_rsp_if.source        rsp_chan,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   ctl_state_type state_ff, state_in;
   logic [CFG_W-1:0]  win_ff;
   logic [ADDR_W-1:0] wp_ff, top_ff;
   logic [CNT_W-1:0]  seen_ff, cur_seen_ff, half_ff, k_ff;
   logic              eos_ff;
   logic              rsp_valid_ff, rsp_final_ff;
   logic [SAMPLE_WIDTH:0] rsp_value_ff;

   logic [CFG_W-1:0] win_eff;
   logic [CNT_W-1:0] half_now, kmax, span, k_sum_lim;
   logic [CNT_W:0]   k_sum, two_half;
   logic accept, start, res_ack, has_result;
   job_type job;
   sel_status_type sel_status;
   logic [SAMPLE_WIDTH:0] sel_value;
   logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
   logic [SAMPLE_WIDTH-1:0] rd_data_a, rd_data_b;

   assign win_eff  = (win_ff > CFG_W'(MAX_WINDOW)) ? CFG_W'(MAX_WINDOW) : win_ff;
   assign half_now = CNT_W'(win_eff >> 1);
   assign kmax     = (half_now < seen_ff) ? half_now : seen_ff;
   assign has_result = req_chan.end_of_signal || (seen_ff >= half_now);
   assign accept   = req_chan.valid && req_chan.ready;

   // window span behind the newest sample for the current result
   assign k_sum     = {1'b0, k_ff} + {1'b0, half_ff};
   assign two_half  = {half_ff, 1'b0};
   assign k_sum_lim = eos_ff ? ((k_sum > {1'b0, cur_seen_ff}) ? cur_seen_ff : CNT_W'(k_sum))
                             : ((two_half > {1'b0, cur_seen_ff}) ? cur_seen_ff
                                                                 : CNT_W'(two_half));
   assign span = k_sum_lim;

   assign job.top  = top_ff;
   assign job.cnt  = span + CNT_W'(1);
   assign job.last = eos_ff && (k_ff == '0);

   assign res_ack = sel_status.valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_IDLE: if (accept && has_result) state_in = CTL_RUN;
         CTL_RUN:  state_in = CTL_WAIT;
         CTL_WAIT: begin
            if (res_ack) begin
               state_in = (eos_ff && k_ff != '0) ? CTL_RUN : CTL_IDLE;
            end
         end
         default:  state_in = CTL_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = (state_ff == CTL_IDLE);
      start          = (state_ff == CTL_RUN);
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.median_value = rsp_value_ff;
   assign rsp_chan.final_result = rsp_final_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         win_ff       <= CFG_RESET;
         wp_ff        <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            win_ff <= csr_wr_data;
         end
         if (accept) begin
            if (req_chan.end_of_signal) begin
               wp_ff   <= '0;
               seen_ff <= '0;
            end else begin
               wp_ff <= wp_ff + ADDR_W'(1);
               if (seen_ff != '1) seen_ff <= seen_ff + CNT_W'(1);
            end
         end
         if (res_ack) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         top_ff      <= wp_ff;
         cur_seen_ff <= seen_ff;
         half_ff     <= half_now;
         eos_ff      <= req_chan.end_of_signal;
         k_ff        <= req_chan.end_of_signal ? kmax : '0;
      end else if (state_ff == CTL_WAIT && res_ack && k_ff != '0) begin
         k_ff <= k_ff - CNT_W'(1);
      end
      if (res_ack) begin
         rsp_value_ff <= sel_value;
         rsp_final_ff <= sel_status.last;
      end
   end

   swm_store #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_store (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (wp_ff),
      .wr_data   (req_chan.sample),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   swm_select #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_select (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .job       (job),
      .status    (sel_status),
      .res_value (sel_value),
      .res_ack   (res_ack),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

endmodule

// ===== hw/rtl/swm_checker.sv =====
// Port-level checker for the running median filter, bound to the top level
module swm_checker
   import swm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_eos,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [SAMPLE_WIDTH:0] rsp_value
);

`include "sliding_window_median_top_assert.svh"

   // stalled result holds its value
   `SWM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value))
   // input side closes after an accepted end of signal, which always produces at least one result
   `SWM_ASSERT_NEXT(a_eos_busy, req_valid && req_ready && req_eos, !req_ready)
   // input side closes only on an accepted item
   `SWM_ASSERT_NOW(a_ready_drop, $fell(req_ready), $past(req_valid))

endmodule

bind sliding_window_median_top swm_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_swm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_eos   (req_chan.end_of_signal),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_value (rsp_chan.median_value)
);
